[rtl/pir_pkg.sv]
// Shared constants, types and helper functions for the perifocal-to-inertial rotation.
package pir_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int VEC_W = 48;
  localparam int ANG_W = 32;
  localparam int CW = 36;                       // CORDIC datapath width (Q30 plus headroom)
  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

  localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [CW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [CW-1:0] Q30_GAIN    = 36'sd652032874;
  localparam logic signed [VEC_W-1:0] OUT_MAX  = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] OUT_MIN  = {1'b1, {(VEC_W-1){1'b0}}};

  typedef logic signed [CW-1:0] q30_t;

  typedef struct packed {
    q30_t x;
    q30_t y;
    q30_t z;
    logic flip;
  } cordic_t;

  function automatic q30_t atan_step(input int i);
    q30_t r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: r = (i <= 30) ? (q30_t'(1) <<< (30 - i)) : '0;
    endcase
    return r;
  endfunction

  // Q30 product rounded to nearest: floor((a*b + 2^29) / 2^30).
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (72'sd1 <<< 29);
    return q30_t'(p >>> 30);
  endfunction

  // Wraps the Q4.28 angle into [-pi/2, pi/2] and starts a CORDIC vector.
  function automatic cordic_t cordic_init(input logic [ANG_W-1:0] raw);
    cordic_t c;
    q30_t z;
    z = q30_t'($signed(raw)) <<< 2;
    if (z > Q30_PI) z = z - Q30_TWO_PI;
    if (z > Q30_PI) z = z - Q30_TWO_PI;
    if (z < -Q30_PI) z = z + Q30_TWO_PI;
    if (z < -Q30_PI) z = z + Q30_TWO_PI;
    c.flip = 1'b0;
    if (z > Q30_HALF_PI) begin
      z = z - Q30_PI;
      c.flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      z = z + Q30_PI;
      c.flip = 1'b1;
    end
    c.x = Q30_GAIN;
    c.y = '0;
    c.z = z;
    return c;
  endfunction

endpackage

[rtl/pir_if.sv]
// Valid/ready stream interfaces for the input and result channels.
interface pir_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [pir_pkg::VEC_W-1:0] plane_x;
  logic [pir_pkg::VEC_W-1:0] plane_y;
  logic [pir_pkg::ANG_W-1:0] node_angle;
  logic [pir_pkg::ANG_W-1:0] perigee_angle;
  logic [pir_pkg::ANG_W-1:0] tilt_angle;
  modport source (output valid, plane_x, plane_y, node_angle, perigee_angle, tilt_angle,
                  input ready);
  modport sink (input valid, plane_x, plane_y, node_angle, perigee_angle, tilt_angle,
                output ready);
endinterface

interface pir_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [pir_pkg::VEC_W-1:0] frame_x;
  logic [pir_pkg::VEC_W-1:0] frame_y;
  logic [pir_pkg::VEC_W-1:0] frame_z;
  modport source (output valid, frame_x, frame_y, frame_z, input ready);
  modport sink (input valid, frame_x, frame_y, frame_z, output ready);
endinterface

[rtl/perifocal_to_inertial_rotation.sv]
// Top level: CORDIC cell chain, matrix stages and the pipeline valid control.
// An accepted input beat passes the input register, the CORDIC cells and the matrix stages to its result beat.
// Throughput: one beat per cycle while the output is not stalled; the CORDIC cells and matrix stages set the depth.
// The whole pipeline advances as one when the output register is free or taken.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// No state is kept between items; each beat carries its own angles.
module perifocal_to_inertial_rotation (
  input logic clk,
  input logic rst_n,
  pir_in_if.sink   in_ch,
  pir_out_if.source out_ch
);
  import pir_pkg::*;

  localparam int DEPTH = CORDIC_STEPS + 7;

  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic adv;

  cordic_t chain_a [CORDIC_STEPS+1][3];
  logic [2*VEC_W-1:0] chain_v [CORDIC_STEPS+1];
  cordic_t init_r [3];
  logic [2*VEC_W-1:0] init_v_r;
  logic [3*VEC_W-1:0] res;

  // Stall only when the last stage holds a result that is not taken.
  assign adv = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      init_r[0] <= cordic_init(in_ch.node_angle);
      init_r[1] <= cordic_init(in_ch.perigee_angle);
      init_r[2] <= cordic_init(in_ch.tilt_angle);
      init_v_r <= {in_ch.plane_y, in_ch.plane_x};
    end
  end

  assign chain_a[0] = init_r;
  assign chain_v[0] = init_v_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    pir_cell u_cell (
      .clk     (clk),
      .en      (adv),
      .step    (STEP_W'(g)),
      .a_in    (chain_a[g]),
      .vec_in  (chain_v[g]),
      .a_out   (chain_a[g+1]),
      .vec_out (chain_v[g+1])
    );
  end

  pir_matrix u_matrix (
    .clk     (clk),
    .en      (adv),
    .a_in    (chain_a[CORDIC_STEPS]),
    .vec_in  (chain_v[CORDIC_STEPS]),
    .res_out (res)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (adv) vld_nxt = {vld_r[DEPTH-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  assign out_ch.valid = vld_r[DEPTH-1];
  assign out_ch.frame_x = res[VEC_W-1:0];
  assign out_ch.frame_y = res[2*VEC_W-1:VEC_W];
  assign out_ch.frame_z = res[3*VEC_W-1:2*VEC_W];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.frame_x))
    else $error("result changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready && !in_ch.valid |=> $countones(vld_r) <= $countones($past(vld_r)))
    else $error("beat invented");
endmodule

[rtl/pir_cell.sv]
// One CORDIC micro-rotation cell for the three angles, passing the vector along each cycle that en is high.
module pir_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pir_pkg::STEP_W-1:0]  step,
  input  pir_pkg::cordic_t            a_in [3],
  input  logic [2*pir_pkg::VEC_W-1:0] vec_in,
  output pir_pkg::cordic_t            a_out [3],
  output logic [2*pir_pkg::VEC_W-1:0] vec_out
);
  import pir_pkg::*;

  cordic_t a_nxt [3];
  cordic_t a_r [3];
  logic [2*VEC_W-1:0] vec_r;
  q30_t ang;

  always_comb begin
    ang = atan_step(int'(step));
    for (int k = 0; k < 3; k++) begin
      a_nxt[k] = a_in[k];
      if (!a_in[k].z[CW-1]) begin
        a_nxt[k].x = a_in[k].x - (a_in[k].y >>> step);
        a_nxt[k].y = a_in[k].y + (a_in[k].x >>> step);
        a_nxt[k].z = a_in[k].z - ang;
      end else begin
        a_nxt[k].x = a_in[k].x + (a_in[k].y >>> step);
        a_nxt[k].y = a_in[k].y - (a_in[k].x >>> step);
        a_nxt[k].z = a_in[k].z + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      vec_r <= vec_in;
    end
  end

  assign a_out = a_r;
  assign vec_out = vec_r;
endmodule

[rtl/pir_matrix.sv]
// Rotation matrix products and final multiply-accumulate with saturation, in registered stages.
module pir_matrix (
  input  logic                        clk,
  input  logic                        en,
  input  pir_pkg::cordic_t            a_in [3],
  input  logic [2*pir_pkg::VEC_W-1:0] vec_in,
  output logic [3*pir_pkg::VEC_W-1:0] res_out
);
  import pir_pkg::*;

  localparam int PW = VEC_W + CW;     // one vector-by-element product
  localparam int SW = PW + 1;
  localparam int HW = VEC_W - 24 + CW; // upper vector half times an element
  localparam int LW = 25 + CW;         // lower 24 vector bits times an element

  // Stage 1: signed sines and cosines.
  q30_t sn_r, cn_r, sp_r, cp_r, si_r, ci_r;
  logic [2*VEC_W-1:0] v1_r;
  // Stage 2: pairwise products.
  q30_t cncp_r, snsp_r, cnsp_r, sncp_r, sisp_r, sicp_r, ci2_r;
  logic [2*VEC_W-1:0] v2_r;
  // Stage 3: triple products.
  q30_t m_a_r, m_b_r, m_c_r, m_d_r, cncp3_r, snsp3_r, cnsp3_r, sncp3_r, r31_r, r32_r;
  logic [2*VEC_W-1:0] v3_r;
  // Stage 4: matrix elements.
  q30_t r_r [6];
  logic [2*VEC_W-1:0] v4_r;
  // Stage 5: partial products with the vector, split at bit 24.
  logic signed [HW-1:0] ph_r [6];
  logic signed [LW-1:0] pl_r [6];
  // Stage 6: rounded, saturated outputs.
  logic [3*VEC_W-1:0] res_r;

  function automatic q30_t fixsgn(input cordic_t c, input logic want_sin);
    q30_t v;
    v = want_sin ? c.y : c.x;
    return c.flip ? -v : v;
  endfunction

  function automatic logic [VEC_W-1:0] finish(input logic signed [HW-1:0] ah,
                                              input logic signed [LW-1:0] al,
                                              input logic signed [HW-1:0] bh,
                                              input logic signed [LW-1:0] bl);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] q;
    s = (SW'(ah) <<< 24) + SW'(al) + (SW'(bh) <<< 24) + SW'(bl) + (SW'(1) <<< 29);
    q = s >>> 30;
    if (q > SW'(OUT_MAX)) return OUT_MAX;
    if (q < SW'(OUT_MIN)) return OUT_MIN;
    return q[VEC_W-1:0];
  endfunction

  logic signed [VEC_W-25:0] px_hi, py_hi;
  logic signed [24:0] px_lo, py_lo;
  assign px_hi = $signed(v4_r[VEC_W-1:24]);
  assign px_lo = $signed({1'b0, v4_r[23:0]});
  assign py_hi = $signed(v4_r[2*VEC_W-1:VEC_W+24]);
  assign py_lo = $signed({1'b0, v4_r[VEC_W+23:VEC_W]});

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= fixsgn(a_in[0], 1'b1);
      cn_r <= fixsgn(a_in[0], 1'b0);
      sp_r <= fixsgn(a_in[1], 1'b1);
      cp_r <= fixsgn(a_in[1], 1'b0);
      si_r <= fixsgn(a_in[2], 1'b1);
      ci_r <= fixsgn(a_in[2], 1'b0);
      v1_r <= vec_in;

      cncp_r <= mulq(cn_r, cp_r);
      snsp_r <= mulq(sn_r, sp_r);
      cnsp_r <= mulq(cn_r, sp_r);
      sncp_r <= mulq(sn_r, cp_r);
      sisp_r <= mulq(sp_r, si_r);
      sicp_r <= mulq(cp_r, si_r);
      ci2_r  <= ci_r;
      v2_r <= v1_r;

      m_a_r <= mulq(snsp_r, ci2_r);
      m_b_r <= mulq(sncp_r, ci2_r);
      m_c_r <= mulq(cnsp_r, ci2_r);
      m_d_r <= mulq(cncp_r, ci2_r);
      cncp3_r <= cncp_r;
      snsp3_r <= snsp_r;
      cnsp3_r <= cnsp_r;
      sncp3_r <= sncp_r;
      r31_r <= sisp_r;
      r32_r <= sicp_r;
      v3_r <= v2_r;

      r_r[0] <= cncp3_r - m_a_r;
      r_r[1] <= -(cnsp3_r + m_b_r);
      r_r[2] <= sncp3_r + m_c_r;
      r_r[3] <= -(snsp3_r - m_d_r);
      r_r[4] <= r31_r;
      r_r[5] <= r32_r;
      v4_r <= v3_r;

      // Each vector component is split into a signed upper part and an unsigned
      // lower 24 bits; the halves are recombined exactly in the last stage.
      for (int k = 0; k < 3; k++) begin
        ph_r[2*k]   <= HW'(px_hi) * HW'(r_r[2*k]);
        pl_r[2*k]   <= LW'(px_lo) * LW'(r_r[2*k]);
        ph_r[2*k+1] <= HW'(py_hi) * HW'(r_r[2*k+1]);
        pl_r[2*k+1] <= LW'(py_lo) * LW'(r_r[2*k+1]);
      end

      res_r <= {finish(ph_r[4], pl_r[4], ph_r[5], pl_r[5]),
                finish(ph_r[2], pl_r[2], ph_r[3], pl_r[3]),
                finish(ph_r[0], pl_r[0], ph_r[1], pl_r[1])};
    end
  end

  assign res_out = res_r;
endmodule
